>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, opcode and status codes and pipeline types of the complex
// arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;

   localparam int OP_W   = 3;
   localparam int STAT_W = 2;
   localparam int KIND_W = 2;

   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int PASS_W     = 2 * DATA_WIDTH + 1;
   localparam int QB         = DATA_WIDTH + 1;
   localparam int MW         = 3 * DATA_WIDTH + FRAC_BITS + 1;
   localparam int NUM_STAGES = QB + 3;

   localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
   localparam logic [OP_W-1:0] OP_CONJ = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
   localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
   localparam logic [STAT_W-1:0] ST_DZ  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_PASS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIV  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DZ   = 2'd2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      data_type                 a_re;
      data_type                 a_im;
      data_type                 b_re;
      data_type                 b_im;
      logic signed [PROD_W-1:0] p_rr;
      logic signed [PROD_W-1:0] p_ii;
      logic signed [PROD_W-1:0] p_ri;
      logic signed [PROD_W-1:0] p_ir;
      logic signed [PROD_W-1:0] p_bb;
      logic signed [PROD_W-1:0] p_cc;
   } mul_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [PASS_W-1:0] val_re;
      logic signed [PASS_W-1:0] val_im;
      logic                     neg_re;
      logic                     neg_im;
      logic                     ovf_re;
      logic                     ovf_im;
      logic [MW-1:0]            rem_re;
      logic [MW-1:0]            rem_im;
      logic [MW-1:0]            div;
      logic [QB-1:0]            q_re;
      logic [QB-1:0]            q_im;
   } cell_type;

   typedef struct packed {
      data_type          res_re;
      data_type          res_im;
      logic [STAT_W-1:0] status;
   } out_type;

endpackage

>>> rtl/cau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_req_if / cau_rsp_if
// Valid/ready channels for operand transactions and result transactions.
// ----------------------------------------------------------------------------
interface cau_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cau_pkg::OP_W-1:0]             op;
   logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
   logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
   logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
   logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;

   modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
   modport monitor (input valid, ready, op, a_re, a_im, b_re, b_im);
endinterface

interface cau_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cau_pkg::DATA_WIDTH-1:0] res_re;
   logic signed [cau_pkg::DATA_WIDTH-1:0] res_im;
   logic [cau_pkg::STAT_W-1:0]            status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink   (input valid, res_re, res_im, status, output ready);
   modport monitor (input valid, ready, res_re, res_im, status);
endinterface

>>> rtl/cau_mul_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_mul_stage
// First pipeline stage: registers the operands and the six partial products.
// ----------------------------------------------------------------------------
module cau_mul_stage (
   input  logic                         clock,
   input  logic                         load,
   input  logic [cau_pkg::OP_W-1:0]     op,
   input  cau_pkg::data_type            a_re,
   input  cau_pkg::data_type            a_im,
   input  cau_pkg::data_type            b_re,
   input  cau_pkg::data_type            b_im,
   output cau_pkg::mul_type             mul_q
);
   import cau_pkg::*;

   mul_type mul_ff;
   mul_type mul_in;

   always_comb begin
      mul_in.op   = op;
      mul_in.a_re = a_re;
      mul_in.a_im = a_im;
      mul_in.b_re = b_re;
      mul_in.b_im = b_im;
      mul_in.p_rr = PROD_W'(a_re * b_re);
      mul_in.p_ii = PROD_W'(a_im * b_im);
      mul_in.p_ri = PROD_W'(a_re * b_im);
      mul_in.p_ir = PROD_W'(a_im * b_re);
      mul_in.p_bb = PROD_W'(b_re * b_re);
      mul_in.p_cc = PROD_W'(b_im * b_im);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mul_ff <= mul_in;
      end
   end

   assign mul_q = mul_ff;
endmodule

>>> rtl/cau_prep_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_prep_stage
// Second pipeline stage: sums, rescaling, numerator magnitudes, divisor and
// quotient range check for the divider chain.
// ----------------------------------------------------------------------------
module cau_prep_stage (
   input  logic              clock,
   input  logic              load,
   input  cau_pkg::mul_type  mul_d,
   output cau_pkg::cell_type cell_q
);
   import cau_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;

   logic signed [PASS_W-1:0] mre;
   logic signed [PASS_W-1:0] mim;
   logic signed [PASS_W-1:0] nre;
   logic signed [PASS_W-1:0] nim;
   logic signed [PASS_W-1:0] are;
   logic signed [PASS_W-1:0] aim;
   logic signed [PASS_W-1:0] bre;
   logic signed [PASS_W-1:0] bim;
   logic signed [PASS_W-1:0] abs_re;
   logic signed [PASS_W-1:0] abs_im;
   logic [PROD_W-1:0]        den;
   logic [MW-1:0]            den_w;

   function automatic logic signed [PASS_W-1:0] trunc_frac(
      input logic signed [PASS_W-1:0] x);
      logic signed [PASS_W-1:0] bias;
      bias = x[PASS_W-1] ? PASS_W'((64'd1 << FRAC_BITS) - 64'd1) : '0;
      return (x + bias) >>> FRAC_BITS;
   endfunction

   always_comb begin
      are = PASS_W'(mul_d.a_re);
      aim = PASS_W'(mul_d.a_im);
      bre = PASS_W'(mul_d.b_re);
      bim = PASS_W'(mul_d.b_im);
      mre = trunc_frac(PASS_W'(mul_d.p_rr) - PASS_W'(mul_d.p_ii));
      mim = trunc_frac(PASS_W'(mul_d.p_ri) + PASS_W'(mul_d.p_ir));
      nre = PASS_W'(mul_d.p_rr) + PASS_W'(mul_d.p_ii);
      nim = PASS_W'(mul_d.p_ir) - PASS_W'(mul_d.p_ri);
      abs_re = nre[PASS_W-1] ? -nre : nre;
      abs_im = nim[PASS_W-1] ? -nim : nim;
      den   = mul_d.p_bb[PROD_W-1:0] + mul_d.p_cc[PROD_W-1:0];
      den_w = MW'(den);

      cell_in.kind   = KIND_PASS;
      cell_in.val_re = '0;
      cell_in.val_im = '0;
      case (mul_d.op)
         OP_ADD: begin
            cell_in.val_re = are + bre;
            cell_in.val_im = aim + bim;
         end
         OP_SUB: begin
            cell_in.val_re = are - bre;
            cell_in.val_im = aim - bim;
         end
         OP_MUL: begin
            cell_in.val_re = mre;
            cell_in.val_im = mim;
         end
         OP_CONJ: begin
            cell_in.val_re = are;
            cell_in.val_im = -aim;
         end
         OP_DIV: begin
            cell_in.kind = (den == '0) ? KIND_DZ : KIND_DIV;
         end
         default: begin
            cell_in.kind = KIND_PASS;
         end
      endcase

      cell_in.neg_re = nre[PASS_W-1];
      cell_in.neg_im = nim[PASS_W-1];
      cell_in.rem_re = MW'(abs_re[PROD_W-1:0]) << FRAC_BITS;
      cell_in.rem_im = MW'(abs_im[PROD_W-1:0]) << FRAC_BITS;
      cell_in.ovf_re = cell_in.rem_re >= (den_w << QB);
      cell_in.ovf_im = cell_in.rem_im >= (den_w << QB);
      cell_in.div    = den_w << (QB - 1);
      cell_in.q_re   = '0;
      cell_in.q_im   = '0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;
endmodule

>>> rtl/cau_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division cell: produces one quotient bit per lane and hands
// the remainders and the halved divisor to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell (
   input  logic              clock,
   input  logic              load,
   input  cau_pkg::cell_type cell_d,
   output cau_pkg::cell_type cell_q
);
   import cau_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;
   logic     ge_re;
   logic     ge_im;

   always_comb begin
      cell_in = cell_d;
      ge_re = cell_d.rem_re >= cell_d.div;
      ge_im = cell_d.rem_im >= cell_d.div;
      cell_in.rem_re = ge_re ? cell_d.rem_re - cell_d.div : cell_d.rem_re;
      cell_in.rem_im = ge_im ? cell_d.rem_im - cell_d.div : cell_d.rem_im;
      cell_in.q_re   = {cell_d.q_re[QB-2:0], ge_re};
      cell_in.q_im   = {cell_d.q_im[QB-2:0], ge_im};
      cell_in.div    = cell_d.div >> 1;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;
endmodule

>>> rtl/cau_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_out_stage
// Last pipeline stage: signs the quotients, saturates both parts and forms
// the status code into the output register.
// ----------------------------------------------------------------------------
module cau_out_stage (
   input  logic              clock,
   input  logic              load,
   input  cau_pkg::cell_type cell_d,
   output cau_pkg::out_type  out_q
);
   import cau_pkg::*;

   localparam logic signed [PASS_W-1:0] MAX_V =
      PASS_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic signed [PASS_W-1:0] MIN_V = -MAX_V - PASS_W'(1);

   out_type out_ff;
   out_type out_in;

   logic signed [PASS_W-1:0] v_re;
   logic signed [PASS_W-1:0] v_im;
   logic                     sat_re;
   logic                     sat_im;
   data_type                 c_re;
   data_type                 c_im;

   function automatic logic signed [PASS_W-1:0] div_val(
      input logic neg, input logic ovf, input logic [QB-1:0] q);
      logic signed [PASS_W-1:0] m;
      m = ovf ? (PASS_W'(1) << DATA_WIDTH) : PASS_W'(q);
      return neg ? -m : m;
   endfunction

   always_comb begin
      case (cell_d.kind)
         KIND_DIV: begin
            v_re = div_val(cell_d.neg_re, cell_d.ovf_re, cell_d.q_re);
            v_im = div_val(cell_d.neg_im, cell_d.ovf_im, cell_d.q_im);
         end
         KIND_DZ: begin
            v_re = '0;
            v_im = '0;
         end
         default: begin
            v_re = cell_d.val_re;
            v_im = cell_d.val_im;
         end
      endcase
      sat_re = (v_re > MAX_V) || (v_re < MIN_V);
      sat_im = (v_im > MAX_V) || (v_im < MIN_V);
      c_re = (v_re > MAX_V) ? MAX_V[DATA_WIDTH-1:0] :
             (v_re < MIN_V) ? MIN_V[DATA_WIDTH-1:0] : v_re[DATA_WIDTH-1:0];
      c_im = (v_im > MAX_V) ? MAX_V[DATA_WIDTH-1:0] :
             (v_im < MIN_V) ? MIN_V[DATA_WIDTH-1:0] : v_im[DATA_WIDTH-1:0];
      out_in.res_re = c_re;
      out_in.res_im = c_im;
      if (cell_d.kind == KIND_DZ) begin
         out_in.status = ST_DZ;
      end else if (sat_re || sat_im) begin
         out_in.status = ST_SAT;
      end else begin
         out_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign out_q = out_ff;
endmodule

>>> rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed-point operands: add, subtract,
// multiply, conjugate and divide through a chain of restoring division cells.
//
//   channel   dir   payload
//   req_if    in    op, a_re, a_im, b_re, b_im
//   rsp_if    out   res_re, res_im, status
//
// one transaction per cycle sustained while the result side accepts; the
// pipeline is the multiply stage, the prep stage, one division cell per
// quotient bit and the output register
// every stage holds while the stage after it is full and stalled, so bubbles
// collapse and new transactions enter while a result waits
// synchronous reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);
   import cau_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] go;

   mul_type  mul_q;
   cell_type cell_q [QB+1];
   out_type  out_q;

   always_comb begin
      go[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_if.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         go[i] = !valid_ff[i] || go[i+1];
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (i == 0) begin
            valid_in[i] = go[i] ? req_if.valid : valid_ff[i];
         end else begin
            valid_in[i] = go[i] ? valid_ff[i-1] : valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   cau_mul_stage u_mul (
      .clock (clock),
      .load  (go[0]),
      .op    (req_if.op),
      .a_re  (req_if.a_re),
      .a_im  (req_if.a_im),
      .b_re  (req_if.b_re),
      .b_im  (req_if.b_im),
      .mul_q (mul_q)
   );

   cau_prep_stage u_prep (
      .clock  (clock),
      .load   (go[1]),
      .mul_d  (mul_q),
      .cell_q (cell_q[0])
   );

   for (genvar k = 0; k < QB; k++) begin : g_cell
      cau_div_cell u_cell (
         .clock  (clock),
         .load   (go[k+2]),
         .cell_d (cell_q[k]),
         .cell_q (cell_q[k+1])
      );
   end

   cau_out_stage u_out (
      .clock  (clock),
      .load   (go[NUM_STAGES-1]),
      .cell_d (cell_q[QB]),
      .out_q  (out_q)
   );

   assign req_if.ready  = go[0];
   assign rsp_if.valid  = valid_ff[NUM_STAGES-1];
   assign rsp_if.res_re = out_q.res_re;
   assign rsp_if.res_im = out_q.res_im;
   assign rsp_if.status = out_q.status;
endmodule

>>> rtl/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
   input logic       clock,
   input logic       reset,
   cau_rsp_if.source rsp_if
);
   import cau_pkg::*;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.status == ST_OK || rsp_if.status == ST_SAT ||
                        rsp_if.status == ST_DZ))
      else $error("undefined status code");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == ST_DZ) |->
         (rsp_if.res_re == '0 && rsp_if.res_im == '0))
      else $error("divide by zero result not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=>
         (rsp_if.valid && $stable(rsp_if.res_re) && $stable(rsp_if.res_im) &&
          $stable(rsp_if.status)))
      else $error("stalled result transaction changed");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_if (rsp_if)
);

>>> test/complex_arithmetic_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_test
// Drives operand transactions into the complex arithmetic unit with bursty
// input and a stalling result side, predicts every result in fixed point and
// checks each result transaction field by field, in order.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_test;
   import cau_pkg::*;

   typedef struct {
      data_type          re;
      data_type          im;
      logic [STAT_W-1:0] status;
   } cplx_result_type;

   class result_scoreboard;
      cplx_result_type pending[$];
      int mismatches;

      function automatic longint clip(longint v, ref bit sat);
         longint hi, lo;
         hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) begin
            sat = 1;
            return hi;
         end
         if (v < lo) begin
            sat = 1;
            return lo;
         end
         return v;
      endfunction

      function void note_operands(logic [OP_W-1:0] op, data_type ar_s, data_type ai_s,
                                  data_type br_s, data_type bi_s);
         longint ar, ai, br, bi, one, re, im, den;
         logic [STAT_W-1:0] st;
         bit sat;
         cplx_result_type r;
         ar = ar_s;
         ai = ai_s;
         br = br_s;
         bi = bi_s;
         one = longint'(1) <<< FRAC_BITS;
         re = 0;
         im = 0;
         st = ST_OK;
         sat = 0;
         case (op)
            OP_ADD: begin
               re = ar + br;
               im = ai + bi;
            end
            OP_SUB: begin
               re = ar - br;
               im = ai - bi;
            end
            OP_MUL: begin
               re = (ar * br - ai * bi) / one;
               im = (ar * bi + ai * br) / one;
            end
            OP_CONJ: begin
               re = ar;
               im = -ai;
            end
            OP_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  st = ST_DZ;
               end else begin
                  re = ((ar * br + ai * bi) * one) / den;
                  im = ((ai * br - ar * bi) * one) / den;
               end
            end
            default: ;
         endcase
         re = clip(re, sat);
         im = clip(im, sat);
         if (st == ST_OK && sat) st = ST_SAT;
         r.re = data_type'(re);
         r.im = data_type'(im);
         r.status = st;
         pending.push_back(r);
      endfunction

      function void check_result(data_type re, data_type im, logic [STAT_W-1:0] st);
         cplx_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d %0d %0d", re, im, st);
            return;
         end
         e = pending.pop_front();
         if (re !== e.re || im !== e.im || st !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        e.re, e.im, e.status, re, im, st);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   stall_mode = 0;
   result_scoreboard board = new();

   cau_req_if req_if();
   cau_rsp_if rsp_if();

   complex_arithmetic_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always #6 clock = ~clock;

   initial begin
      req_if.valid = 0;
      req_if.op = OP_ADD;
      req_if.a_re = 0;
      req_if.a_im = 0;
      req_if.b_re = 0;
      req_if.b_im = 0;
      rsp_if.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            board.note_operands(req_if.op, req_if.a_re, req_if.a_im, req_if.b_re, req_if.b_im);
         if (rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.res_re, rsp_if.res_im, rsp_if.status);
      end
   end

   // receiver stall pattern, changes character now and then
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_if.ready <= 1;
         1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_if.ready <= ($urandom_range(0, 1) != 0);
         default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 0;
         3: return data_type'($urandom_range(0, 8191)) - 16'sd4096;
         4: return data_type'($urandom_range(0, 3)) - 16'sd1;
         default: return data_type'($urandom);
      endcase
   endfunction

   task automatic send_operands(logic [OP_W-1:0] op, data_type ar, data_type ai,
                                data_type br, data_type bi);
      req_if.valid <= 1;
      req_if.op <= op;
      req_if.a_re <= ar;
      req_if.a_im <= ai;
      req_if.b_re <= br;
      req_if.b_im <= bi;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      req_if.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int burst;
      int sent;
      logic [OP_W-1:0] op;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_operands(OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_operands(OP_ADD, 16'sh0001, 16'shffff, 16'sh0002, 16'sh0003);
      send_operands(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_operands(OP_SUB, 16'sh1000, 16'sh2000, 16'sh0800, 16'sh0400);
      send_operands(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_operands(OP_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
      send_operands(OP_MUL, 16'sh1000, 16'sh1000, 16'sh1000, 16'shf000);
      send_operands(OP_MUL, 16'shffff, 16'sh0001, 16'sh0001, 16'sh0001);
      send_operands(OP_CONJ, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
      send_operands(OP_CONJ, 16'sh7fff, 16'sh7fff, 16'sh1234, 16'sh5678);
      send_operands(OP_CONJ, 16'sh1234, 16'sh0000, 16'sh0000, 16'sh0000);
      send_operands(OP_DIV, 16'sh1000, 16'sh1000, 16'sh0000, 16'sh0000);
      send_operands(OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000);
      send_operands(OP_DIV, 16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000);
      send_operands(OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
      send_operands(OP_DIV, 16'sh8000, 16'sh8000, 16'sh0001, 16'shffff);
      send_operands(OP_DIV, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000);
      send_operands(OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_operands(OP_DIV, 16'sh2000, 16'sh1000, 16'sh1000, 16'shf000);
      send_operands(3'd5, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234);
      send_operands(3'd6, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      send_operands(3'd7, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
      wait_drained();
      sent = 0;
      while (sent < 1500) begin
         burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
         repeat (burst) begin
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            if (op == OP_DIV && $urandom_range(0, 15) == 0)
               send_operands(op, pick_value(), pick_value(), 0, 0);
            else
               send_operands(op, pick_value(), pick_value(), pick_value(), pick_value());
            sent++;
         end
         if (sent > 700 && sent < 760) wait_drained();
         else if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
      end
      wait_drained();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end
endmodule
